### rtl/core/byte_range_request_limiter_assert.svh
// ----------------------------------------------------------------------------
// Byte-range request limiter: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_RANGE_REQUEST_LIMITER_ASSERT_SVH
`define BYTE_RANGE_REQUEST_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brl assertion failed");

// next-cycle implication
`define BRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brl assertion failed");

`else

`define BRL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/brl_pkg.sv
// ----------------------------------------------------------------------------
// Byte-range request limiter package
// Shared widths, verdict codes, register indexes and the row control bundle.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int VALUE_W = 32;
    localparam int LIMIT_W = 8;
    localparam int TALLY_W = 9;

    localparam logic [TALLY_W-1:0] RANGE_TALLY_MAX   = 9'd256;
    localparam logic [TALLY_W-1:0] OVERLAP_TALLY_MAX = 9'd511;

    localparam logic [LIMIT_W-1:0] RANGE_LIMIT_RESET   = 8'd20;
    localparam logic [LIMIT_W-1:0] OVERLAP_LIMIT_RESET = 8'd5;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPT   = 2'd0,
        VERDICT_UNSAT    = 2'd1,
        VERDICT_RANGES   = 2'd2,
        VERDICT_OVERLAPS = 2'd3
    } t_verdict;

    // configuration register indexes
    typedef enum logic {
        CFG_RANGE_LIMIT   = 1'b0,
        CFG_OVERLAP_LIMIT = 1'b1
    } t_cfg_index;

    // per-request control for one row of cells
    typedef struct packed {
        logic en;     // request accepted this cycle
        logic clear;  // request opens a new header
        logic store;  // request passed checks, value may be stored
    } t_row_ctrl;

endpackage

### rtl/core/byte_range_request_limiter.sv
// ----------------------------------------------------------------------------
// Byte-range request limiter
// Checks the ranges of one byte-range header, keeps distinct starts and ends
// in two rows of cells, counts ranges and repeats, and holds a sticky verdict.
//
//   channel   handshake                    payload
//   --------  ---------------------------  -------------------------------------
//   input     i_valid / o_ready            i_first_range, i_range_start, i_range_end
//   result    o_valid / i_ready            o_verdict, o_ranges_seen, o_overlaps_seen
//   config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request per cycle unless the result stalls; the result appears in the output
// register in the cycle after acceptance. The cycle is set by the single-pass match
// across both cell rows plus the tally update. A stalled result blocks input only
// when the output register is full and not taken. Reset clears fills, tallies and
// verdict and loads the default limits; stored offsets need no clearing.
// ----------------------------------------------------------------------------
`include "byte_range_request_limiter_assert.svh"

module byte_range_request_limiter
    import brl_pkg::*;
#(
    parameter int STORE_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_first_range,
    input  logic signed [VALUE_W-1:0] i_range_start,
    input  logic signed [VALUE_W-1:0] i_range_end,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_verdict,
    output logic [TALLY_W-1:0]        o_ranges_seen,
    output logic [TALLY_W-1:0]        o_overlaps_seen,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [LIMIT_W-1:0]        i_cfg_data
);

    logic [LIMIT_W-1:0] r_range_limit;
    logic [LIMIT_W-1:0] r_overlap_limit;
    t_verdict           r_verdict;
    t_verdict           n_verdict;
    logic [TALLY_W-1:0] r_ranges;
    logic [TALLY_W-1:0] n_ranges;
    logic [TALLY_W-1:0] r_overlaps;
    logic [TALLY_W-1:0] n_overlaps;
    logic               r_out_valid;
    logic [1:0]         r_out_verdict;
    logic [TALLY_W-1:0] r_out_ranges;
    logic [TALLY_W-1:0] r_out_overlaps;

    logic               w_accept;
    t_verdict           w_eff_verdict;
    logic [TALLY_W-1:0] w_eff_ranges;
    logic [TALLY_W-1:0] w_eff_overlaps;
    logic               w_unsat;
    logic               w_go;
    logic               w_start_hit;
    logic               w_end_hit;
    logic [TALLY_W:0]   w_ov_sum;
    logic [TALLY_W-1:0] w_ranges_inc;
    logic [TALLY_W-1:0] w_overlaps_inc;
    t_row_ctrl          w_row_ctrl;

    // handshakes
    assign o_ready     = !r_out_valid || i_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_limit   <= RANGE_LIMIT_RESET;
            r_overlap_limit <= OVERLAP_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RANGE_LIMIT:   r_range_limit   <= i_cfg_data;
                CFG_OVERLAP_LIMIT: r_overlap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header state as seen by this request
    assign w_eff_verdict  = i_first_range ? VERDICT_ACCEPT : r_verdict;
    assign w_eff_ranges   = i_first_range ? '0 : r_ranges;
    assign w_eff_overlaps = i_first_range ? '0 : r_overlaps;

    // negative start, or non-negative end below start
    assign w_unsat = i_range_start[VALUE_W-1] ||
                     (!i_range_end[VALUE_W-1] &&
                      (i_range_end[VALUE_W-2:0] < i_range_start[VALUE_W-2:0]));
    assign w_go = (w_eff_verdict == VERDICT_ACCEPT) && !w_unsat;

    assign w_row_ctrl = '{en: w_accept, clear: i_first_range, store: w_go};

    // distinct starts
    brl_row #(.DEPTH(STORE_DEPTH)) u_start_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_row_ctrl),
        .i_value (i_range_start),
        .o_hit   (w_start_hit)
    );

    // distinct ends
    brl_row #(.DEPTH(STORE_DEPTH)) u_end_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_row_ctrl),
        .i_value (i_range_end),
        .o_hit   (w_end_hit)
    );

    // saturating tallies
    assign w_ov_sum = {1'b0, w_eff_overlaps} + (TALLY_W+1)'(w_start_hit)
                    + (TALLY_W+1)'(w_end_hit);
    assign w_overlaps_inc = (w_ov_sum > {1'b0, OVERLAP_TALLY_MAX}) ? OVERLAP_TALLY_MAX
                                                                  : w_ov_sum[TALLY_W-1:0];
    assign w_ranges_inc = (w_eff_ranges < RANGE_TALLY_MAX) ? (w_eff_ranges + TALLY_W'(1))
                                                           : w_eff_ranges;

    // next verdict and counts
    always_comb begin
        n_verdict  = w_eff_verdict;
        n_ranges   = w_eff_ranges;
        n_overlaps = w_eff_overlaps;
        case (w_eff_verdict)
            VERDICT_ACCEPT: begin
                if (w_unsat) begin
                    n_verdict = VERDICT_UNSAT;
                end else begin
                    n_ranges   = w_ranges_inc;
                    n_overlaps = w_overlaps_inc;
                    if (w_ranges_inc > {1'b0, r_range_limit}) begin
                        n_verdict = VERDICT_RANGES;
                    end else if (w_overlaps_inc > {1'b0, r_overlap_limit}) begin
                        n_verdict = VERDICT_OVERLAPS;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict  <= VERDICT_ACCEPT;
            r_ranges   <= '0;
            r_overlaps <= '0;
        end else if (w_accept) begin
            r_verdict  <= n_verdict;
            r_ranges   <= n_ranges;
            r_overlaps <= n_overlaps;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_verdict  <= n_verdict;
            r_out_ranges   <= n_ranges;
            r_out_overlaps <= n_overlaps;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_out_verdict;
    assign o_ranges_seen   = r_out_ranges;
    assign o_overlaps_seen = r_out_overlaps;

    `BRL_ASSERT_IMPL(a_ranges_bound, i_clk, i_rst_n, 1'b1, r_ranges <= RANGE_TALLY_MAX)
    `BRL_ASSERT_NEXT(a_sticky_hold, i_clk, i_rst_n, w_accept && !i_first_range && (r_verdict != VERDICT_ACCEPT), (o_verdict == $past(r_verdict)) && (o_ranges_seen == $past(r_ranges)))
    `BRL_ASSERT_NEXT(a_unsat_first, i_clk, i_rst_n, w_accept && i_first_range && w_unsat, (o_verdict == VERDICT_UNSAT) && (o_ranges_seen == '0) && (o_overlaps_seen == '0))

endmodule

### rtl/core/brl_cell.sv
// ----------------------------------------------------------------------------
// Byte-range request limiter: store cell
// Holds one stored offset, compares it with the query, and hands its value
// to the next cell when the row inserts.
// ----------------------------------------------------------------------------
module brl_cell
    import brl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_live,
    input  logic [VALUE_W-1:0] i_shift_in,
    input  logic [VALUE_W-1:0] i_query,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_hit
);

    logic [VALUE_W-1:0] r_value;

    // entry register, takes the neighbor's value on insert
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_shift_in;
        end
    end

    // match only inside the filled prefix
    assign o_hit   = i_live && (r_value == i_query);
    assign o_value = r_value;

endmodule

### rtl/core/brl_row.sv
// ----------------------------------------------------------------------------
// Byte-range request limiter: row of store cells
// A chain of cells holding the distinct offsets of one header. New values
// enter at cell 0 and the chain shifts by one; the fill count marks the
// occupied prefix.
// ----------------------------------------------------------------------------
`include "byte_range_request_limiter_assert.svh"

module brl_row
    import brl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_row_ctrl          i_ctrl,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_hit
);

    localparam int FW = $clog2(DEPTH + 1);

    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      n_fill;
    logic [FW-1:0]      w_eff_fill;
    logic               w_insert;
    logic [DEPTH-1:0]   w_hit;
    logic [VALUE_W-1:0] w_value [DEPTH];

    // a new header empties the row before this request is looked up
    assign w_eff_fill = i_ctrl.clear ? '0 : r_fill;

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_in;
        if (g == 0) begin : g_head
            assign w_in = i_value;
        end else begin : g_body
            assign w_in = w_value[g-1];
        end
        brl_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_insert),
            .i_live     (w_eff_fill > FW'(g)),
            .i_shift_in (w_in),
            .i_query    (i_value),
            .o_value    (w_value[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign o_hit = |w_hit;

    // store a miss while room remains
    assign w_insert = i_ctrl.en && i_ctrl.store && !o_hit && (w_eff_fill < FW'(DEPTH));

    always_comb begin
        n_fill = r_fill;
        if (i_ctrl.en) begin
            n_fill = w_insert ? (w_eff_fill + FW'(1)) : w_eff_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    `BRL_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(DEPTH))
    `BRL_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, w_insert, r_fill == $past(w_eff_fill) + FW'(1))
    `BRL_ASSERT_NEXT(a_fill_clear, i_clk, i_rst_n, i_ctrl.en && i_ctrl.clear && !w_insert, r_fill == '0)

endmodule
